// ===== rtl/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Shared payload, command and status types and fixed codes.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int ORDER_W  = 4;
  localparam int INDEX_W  = 16;
  localparam int FREE_W   = 17;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_TRIM  = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOBLK   = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_RELEASE = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [ORDER_W-1:0] block_order;
    logic [INDEX_W-1:0] block_index;
    logic [ORDER_W-1:0] target_order;
  } bpa_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [INDEX_W-1:0] result_index;
    logic [FREE_W-1:0]  free_pages;
  } bpa_out_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_TAKE,
    S_SPLIT_LOOP,
    S_SPLIT_RD,
    S_SPLIT_WR,
    S_FR_RD,
    S_FR_CHK,
    S_MERGE_LOOP,
    S_MATE_RD,
    S_MATE_CHK,
    S_MARK_RD,
    S_MARK_WR
  } bpa_state_t;

  typedef enum logic [1:0] {
    ASEL_BLOCK,
    ASEL_MATE,
    ASEL_HALF,
    ASEL_SCAN
  } bpa_asel_t;

  typedef enum logic [1:0] {
    TOT_NONE,
    TOT_FREE,
    TOT_ALLOC,
    TOT_TRIM
  } bpa_tot_t;

  typedef struct packed {
    logic       clr;
    logic       load;
    logic       start_scan;
    logic       rd;
    bpa_asel_t  asel;
    logic       wr_set;
    logic       wr_clr;
    logic       scan_next;
    logic       scan_take;
    logic       ord_dec;
    logic       merge;
    bpa_tot_t   tot;
    logic       status_we;
    logic [1:0] status;
    logic       res_take;
    logic       out_load;
  } bpa_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic bad_req;
    logic is_alloc;
    logic none_avail;
    logic release_blk;
    logic trim_grow;
    logic trim_same;
    logic rd_bit;
    logic scan_hit;
    logic ord_gt_low;
    logic below_top;
  } bpa_flag_t;

endpackage

// ===== rtl/bpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator controller
// Sequences bitmap read-modify-write steps and the handshakes.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  bpa_pkg::bpa_flag_t  flag,
  output bpa_pkg::bpa_cmd_t   cmd
);
  import bpa_pkg::*;

  bpa_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:      if (flag.clr_done) state_nxt = S_IDLE;
      S_IDLE:       if (in_valid && !in_stall) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        if (flag.bad_req) state_nxt = S_IDLE;
        else if (flag.is_alloc) state_nxt = flag.none_avail ? S_IDLE : S_SCAN_RD;
        else if (flag.release_blk) state_nxt = S_FR_RD;
        else if (flag.trim_same) state_nxt = S_IDLE;
        else state_nxt = S_SPLIT_LOOP;
      end
      S_SCAN_RD:    state_nxt = S_SCAN_CHK;
      S_SCAN_CHK:   state_nxt = flag.scan_hit ? S_TAKE : S_SCAN_RD;
      S_TAKE:       state_nxt = S_SPLIT_LOOP;
      S_SPLIT_LOOP: state_nxt = flag.ord_gt_low ? S_SPLIT_RD : S_IDLE;
      S_SPLIT_RD:   state_nxt = S_SPLIT_WR;
      S_SPLIT_WR:   state_nxt = S_SPLIT_LOOP;
      S_FR_RD:      state_nxt = S_FR_CHK;
      S_FR_CHK:     state_nxt = flag.rd_bit ? S_IDLE : S_MERGE_LOOP;
      S_MERGE_LOOP: state_nxt = flag.below_top ? S_MATE_RD : S_MARK_RD;
      S_MATE_RD:    state_nxt = S_MATE_CHK;
      S_MATE_CHK:   state_nxt = flag.rd_bit ? S_MERGE_LOOP : S_MARK_RD;
      S_MARK_RD:    state_nxt = S_MARK_WR;
      S_MARK_WR:    state_nxt = S_IDLE;
      default:      state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_CLEAR: cmd.clr = 1'b1;
      S_IDLE:  cmd.load = in_valid && !in_stall;
      S_DISPATCH: begin
        if (flag.bad_req) begin
          cmd.status_we = 1'b1;
          cmd.status    = ST_RANGE;
          cmd.out_load  = 1'b1;
        end else if (flag.is_alloc) begin
          if (flag.none_avail) begin
            cmd.status_we = 1'b1;
            cmd.status    = ST_NOBLK;
            cmd.out_load  = 1'b1;
          end else begin
            cmd.start_scan = 1'b1;
          end
        end else if (flag.release_blk) begin
          cmd.status_we = flag.trim_grow;
          cmd.status    = ST_RELEASE;
        end else if (flag.trim_same) begin
          cmd.res_take = 1'b1;
          cmd.out_load = 1'b1;
        end else begin
          cmd.res_take = 1'b1;
          cmd.tot      = TOT_TRIM;
        end
      end
      S_SCAN_RD: begin
        cmd.rd   = 1'b1;
        cmd.asel = ASEL_SCAN;
      end
      S_SCAN_CHK: begin
        cmd.scan_take = flag.scan_hit;
        cmd.scan_next = !flag.scan_hit;
      end
      S_TAKE: begin
        cmd.wr_clr   = 1'b1;
        cmd.tot      = TOT_ALLOC;
        cmd.res_take = 1'b1;
      end
      S_SPLIT_LOOP: begin
        cmd.ord_dec  = flag.ord_gt_low;
        cmd.out_load = !flag.ord_gt_low;
      end
      S_SPLIT_RD: begin
        cmd.rd   = 1'b1;
        cmd.asel = ASEL_HALF;
      end
      S_SPLIT_WR: cmd.wr_set = 1'b1;
      S_FR_RD: begin
        cmd.rd   = 1'b1;
        cmd.asel = ASEL_BLOCK;
      end
      S_FR_CHK: begin
        cmd.tot      = flag.rd_bit ? TOT_NONE : TOT_FREE;
        cmd.out_load = flag.rd_bit;
      end
      S_MATE_RD: begin
        cmd.rd   = 1'b1;
        cmd.asel = ASEL_MATE;
      end
      S_MATE_CHK: begin
        cmd.wr_clr = flag.rd_bit;
        cmd.merge  = flag.rd_bit;
      end
      S_MARK_RD: begin
        cmd.rd   = 1'b1;
        cmd.asel = ASEL_BLOCK;
      end
      S_MARK_WR: begin
        cmd.wr_set   = 1'b1;
        cmd.out_load = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> in_stall)
    else $error("input taken during bitmap clear");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DISPATCH))
    else $error("accepted transaction not dispatched");

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r || !out_stall || (state_r == S_DISPATCH))
    else $error("result loaded over a stalled result");

endmodule

// ===== rtl/bpa_dpath.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator datapath
// Free bitmap memory, per-order counters, free page total and result register.
// ----------------------------------------------------------------------------
module bpa_dpath #(
  parameter int ORDER_COUNT = 11,
  parameter int INDEX_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bpa_pkg::bpa_in_t   in_data,
  input  bpa_pkg::bpa_cmd_t  cmd,
  output bpa_pkg::bpa_flag_t flag,
  output bpa_pkg::bpa_out_t  out_data
);
  import bpa_pkg::*;

  localparam int PW         = INDEX_BITS + 1;
  localparam int PXW        = (PW > 6) ? PW : 7;
  localparam int WBITS      = (PW > 6) ? PW - 6 : 1;
  localparam int WORD_COUNT = (PW > 6) ? 2 ** (PW - 6) : 1;
  localparam int OIW        = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1;
  localparam int IW         = INDEX_BITS;

  logic [63:0]        mem [WORD_COUNT];
  logic [63:0]        rd_q;
  logic [1:0]         op_r;
  logic [ORDER_W-1:0] k_r, tgt_r, ord_r;
  logic [IW-1:0]      idx_r, res_r;
  logic [1:0]         status_r;
  logic [WBITS-1:0]   w_r, addr_r, clr_r;
  logic [5:0]         bit_r;
  logic [PW-1:0]      total_r, total_nxt;
  logic [PW-1:0]      cnt_r [ORDER_COUNT];
  bpa_out_t           out_r;

  logic [IW-1:0]      idx_in, sel_idx, scan_idx;
  logic [PXW-1:0]     p, s, e1, s_c;
  logic [WBITS-1:0]   p_word;
  logic [63:0]        bitmask, masked, lo_mask, hi_mask;
  logic [5:0]         hit_b;
  logic [ORDER_COUNT-1:0] avail;
  logic [ORDER_W-1:0] first_c, low_ord;
  logic [PW:0]        amt, sum_w, pool;

  function automatic logic [PXW-1:0] bit_pos(input logic [ORDER_W-1:0] k,
                                             input logic [IW-1:0] i);
    bit_pos = (PXW'(1) << (INDEX_BITS - int'(k))) + PXW'(i >> k);
  endfunction

  assign idx_in = IW'(in_data.block_index) & ({IW{1'b1}} << in_data.block_order);

  always_comb begin
    case (cmd.asel)
      ASEL_MATE: sel_idx = idx_r ^ (IW'(1) << ord_r);
      ASEL_HALF: sel_idx = idx_r | (IW'(1) << ord_r);
      default:   sel_idx = idx_r;
    endcase
    p = (cmd.asel == ASEL_SCAN) ? (PXW'(w_r) << 6) : bit_pos(ord_r, sel_idx);
    p_word = WBITS'(p >> 6);
  end

  always_comb begin
    avail = '0;
    for (int j = 0; j < ORDER_COUNT; j++) begin
      avail[j] = (cnt_r[j] != '0) && (j >= int'(k_r)) && (j <= INDEX_BITS);
    end
    first_c = '0;
    for (int j = ORDER_COUNT - 1; j >= 0; j--) begin
      if (avail[j]) first_c = ORDER_W'(j);
    end
    s_c = PXW'(1) << (INDEX_BITS - int'(first_c));
  end

  always_comb begin
    s       = PXW'(1) << (INDEX_BITS - int'(ord_r));
    e1      = (s << 1) - PXW'(1);
    lo_mask = (w_r == WBITS'(s >> 6)) ? ({64{1'b1}} << s[5:0]) : {64{1'b1}};
    hi_mask = {64{1'b1}};
    if ((w_r == WBITS'(e1 >> 6)) && (e1[5:0] != 6'd63)) begin
      hi_mask = (64'd2 << e1[5:0]) - 64'd1;
    end
    masked = rd_q & lo_mask & hi_mask;
    hit_b  = '0;
    for (int b = 63; b >= 0; b--) begin
      if (masked[b]) hit_b = 6'(b);
    end
    scan_idx = IW'((((PXW'(w_r) << 6) | PXW'(hit_b)) - s) << ord_r);
  end

  assign bitmask = 64'd1 << bit_r;
  assign low_ord = (op_r == OP_TRIM) ? tgt_r : k_r;

  always_comb begin
    flag.clr_done    = (clr_r == WBITS'(WORD_COUNT - 1));
    flag.bad_req     = (op_r == OP_RSVD) ||
                       !((int'(k_r) < ORDER_COUNT) && (int'(k_r) <= INDEX_BITS));
    flag.is_alloc    = (op_r == OP_ALLOC);
    flag.none_avail  = (avail == '0);
    flag.trim_grow   = (op_r == OP_TRIM) && (tgt_r > k_r);
    flag.release_blk = (op_r == OP_FREE) || flag.trim_grow;
    flag.trim_same   = (op_r == OP_TRIM) && (tgt_r == k_r);
    flag.rd_bit      = rd_q[bit_r];
    flag.scan_hit    = (masked != '0);
    flag.ord_gt_low  = (ord_r > low_ord);
    flag.below_top   = (int'(ord_r) + 1 < ORDER_COUNT) && (int'(ord_r) < INDEX_BITS);
  end

  always_comb begin
    pool  = (PW + 1)'(1) << INDEX_BITS;
    amt   = (PW + 1)'(1) << k_r;
    sum_w = {1'b0, total_r};
    case (cmd.tot)
      TOT_FREE:  sum_w = sum_w + amt;
      TOT_ALLOC: sum_w = (sum_w < amt) ? '0 : sum_w - amt;
      TOT_TRIM:  sum_w = sum_w + amt - ((PW + 1)'(1) << tgt_r);
      default:   sum_w = {1'b0, total_r};
    endcase
    total_nxt = (sum_w > pool) ? PW'(pool) : PW'(sum_w);
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) mem[clr_r] <= '0;
    else if (cmd.wr_set) mem[addr_r] <= rd_q | bitmask;
    else if (cmd.wr_clr) mem[addr_r] <= rd_q & ~bitmask;
    if (cmd.rd) rd_q <= mem[p_word];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= '0;
      total_r <= '0;
      for (int j = 0; j < ORDER_COUNT; j++) cnt_r[j] <= '0;
    end else begin
      if (cmd.clr) clr_r <= clr_r + WBITS'(1);
      total_r <= total_nxt;
      if (cmd.wr_set && !flag.rd_bit) begin
        cnt_r[ord_r[OIW-1:0]] <= cnt_r[ord_r[OIW-1:0]] + PW'(1);
      end else if (cmd.wr_clr && flag.rd_bit && (cnt_r[ord_r[OIW-1:0]] != '0)) begin
        cnt_r[ord_r[OIW-1:0]] <= cnt_r[ord_r[OIW-1:0]] - PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_data.op;
      k_r      <= in_data.block_order;
      tgt_r    <= in_data.target_order;
      ord_r    <= in_data.block_order;
      idx_r    <= idx_in;
      res_r    <= '0;
      status_r <= ST_DONE;
    end else begin
      if (cmd.start_scan) begin
        ord_r <= first_c;
        w_r   <= WBITS'(s_c >> 6);
      end
      if (cmd.scan_next) w_r <= w_r + WBITS'(1);
      if (cmd.scan_take) begin
        idx_r <= scan_idx;
        bit_r <= hit_b;
      end
      if (cmd.ord_dec) ord_r <= ord_r - ORDER_W'(1);
      if (cmd.merge) begin
        idx_r <= idx_r & ~(IW'(1) << ord_r);
        ord_r <= ord_r + ORDER_W'(1);
      end
      if (cmd.status_we) status_r <= cmd.status;
      if (cmd.res_take) res_r <= idx_r;
    end
    if (cmd.rd) begin
      addr_r <= p_word;
      bit_r  <= p[5:0];
    end
    if (cmd.out_load) begin
      out_r.status       <= cmd.status_we ? cmd.status : status_r;
      out_r.result_index <= cmd.res_take ? INDEX_W'(idx_r) : INDEX_W'(res_r);
      out_r.free_pages   <= FREE_W'(total_nxt);
    end
  end

  assign out_data = out_r;

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= PW'(1) << INDEX_BITS)
    else $error("free page total above pool size");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_set && cmd.wr_clr) && !(cmd.rd && (cmd.wr_set || cmd.wr_clr)))
    else $error("conflicting bitmap accesses");

  a_take_hits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_take |=> flag.rd_bit)
    else $error("taken block not free in bitmap");

endmodule

// ===== rtl/buddy_page_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator unit
// Binary buddy allocator over a page index pool, one result per request.
// ----------------------------------------------------------------------------
// After reset the unit clears its free bitmap, one 64-bit word a cycle,
// 2^(INDEX_BITS-5) words (2048 at the default), before it takes a request.
// Every request runs through a single-port bitmap memory, and each
// read-modify-write step reads a word into a register, then writes it back.
// Allocate scans bitmap words for the lowest free block (up to
// 2^(INDEX_BITS-order-6) words), takes it, then splits it level by level;
// free checks the block, merges it with free buddies and marks the result;
// trim splits or takes the free path. A bad order or op answers at dispatch.
module buddy_page_allocator_unit #(
  parameter int ORDER_COUNT = 11,
  parameter int INDEX_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bpa_pkg::bpa_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bpa_pkg::bpa_out_t out_data
);
  import bpa_pkg::*;

  bpa_cmd_t  cmd;
  bpa_flag_t flag;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .flag      (flag),
    .cmd       (cmd)
  );

  bpa_dpath #(
    .ORDER_COUNT (ORDER_COUNT),
    .INDEX_BITS  (INDEX_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .flag     (flag),
    .out_data (out_data)
  );

endmodule
